/* rtl/core/hcpt_pkg.sv */
package hcpt_pkg;

  // field and register widths
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned PERIOD_W = 15;
  localparam int unsigned CFG_IDX_W = 1;

  // duty full scale in hundredths of a percent
  localparam int unsigned FULL_SCALE   = 10000;
  localparam int unsigned DUTY_FRAC_W  = $clog2(FULL_SCALE);
  localparam int unsigned RESET_PERIOD = 24999;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_MODE = 1'b1;

  // request kinds
  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_DUTY = 1'b1
  } req_e;

  // control travelling from the duty pipeline to the timer core
  typedef struct packed {
    logic valid;
    req_e req;
    logic full;
  } pipe_item_t;

endpackage

/* rtl/core/heat_cool_pwm_timer.sv */
// channel   direction  handshake               payload
// in        input      in_valid_i/in_stall_o   req_type_i, duty_hundredths_i
// out       output     out_valid_o/out_stall_i heat_pin_o, cool_pin_o, counter_value_o,
//                                              counting_o
// cfg       input      cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// one request per cycle sustained while out_stall_i is low; requests traverse
// a five-stage duty pipeline (duty times period, reciprocal multiply, correction)
// ticks ride the same pipeline so requests finish in order
// reset stops the counter, clears count and pins, parks both compares at 24999
// empty stages fill while a result waits; in_stall_o rises only when all five
// stages hold requests and out_stall_i holds the result
module heat_cool_pwm_timer #(
  parameter int unsigned COUNT_WIDTH = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [hcpt_pkg::DUTY_W-1:0]        duty_hundredths_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               heat_pin_o,
  output logic                               cool_pin_o,
  output logic [COUNT_WIDTH-1:0]             counter_value_o,
  output logic                               counting_o,
  input  logic                               cfg_we_i,
  input  logic [hcpt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hcpt_pkg::PERIOD_W-1:0]      cfg_data_i
);
  import hcpt_pkg::*;

  logic [PERIOD_W-1:0]    period_q;
  logic                   cool_mode_q;
  logic [COUNT_WIDTH-1:0] per;
  logic                   core_ready;
  pipe_item_t             item;
  logic [COUNT_WIDTH-1:0] quot;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_W'(RESET_PERIOD);
      cool_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PERIOD:    period_q    <= cfg_data_i;
        CFG_COOL_MODE: cool_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // period as seen by the counter compares
  assign per = COUNT_WIDTH'(period_q);

  hcpt_duty_pipe #(
    .CountWidth (COUNT_WIDTH)
  ) u_duty_pipe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .duty_hundredths_i (duty_hundredths_i),
    .per_i             (per),
    .core_ready_i      (core_ready),
    .item_o            (item),
    .quot_o            (quot)
  );

  hcpt_timer_core #(
    .CountWidth (COUNT_WIDTH)
  ) u_timer_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .quot_i          (quot),
    .per_i           (per),
    .cool_mode_i     (cool_mode_q),
    .core_ready_o    (core_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .heat_pin_o      (heat_pin_o),
    .cool_pin_o      (cool_pin_o),
    .counter_value_o (counter_value_o),
    .counting_o      (counting_o)
  );

endmodule

/* rtl/core/hcpt_duty_pipe.sv */
module hcpt_duty_pipe #(
  parameter int unsigned CountWidth = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [hcpt_pkg::DUTY_W-1:0]       duty_hundredths_i,
  input  logic [CountWidth-1:0]             per_i,
  input  logic                              core_ready_i,
  output hcpt_pkg::pipe_item_t              item_o,
  output logic [CountWidth-1:0]             quot_o
);
  import hcpt_pkg::*;

  localparam int unsigned NumStages = 5;
  localparam int unsigned ProdW     = CountWidth + DUTY_FRAC_W;
  localparam int unsigned RecipW    = CountWidth + 1;
  localparam int unsigned WideW     = ProdW + RecipW;
  // floor(2^ProdW / full scale): quotient estimate is low by at most one
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << ProdW) / FULL_SCALE);

  logic [NumStages-1:0] v_q, v_d, rdy;

  // stage 1: input register
  req_e                   req1_q;
  logic [DUTY_W-1:0]      duty1_q;
  // stage 2: duty times period
  req_e                   req2_q;
  logic                   full2_q;
  logic [ProdW-1:0]       p2_q;
  // stage 3: quotient estimate
  req_e                   req3_q;
  logic                   full3_q;
  logic [ProdW-1:0]       p3_q;
  logic [CountWidth-1:0]  q0_3_q;
  // stage 4: estimate times full scale
  req_e                   req4_q;
  logic                   full4_q;
  logic [ProdW-1:0]       p4_q;
  logic [CountWidth-1:0]  q0_4_q;
  logic [ProdW-1:0]       qm4_q;
  // stage 5: corrected quotient
  req_e                   req5_q;
  logic                   full5_q;
  logic [CountWidth-1:0]  q5_q;

  logic [WideW-1:0]       recip_prod;
  logic [ProdW-1:0]       rem4;
  logic [CountWidth:0]    q_fix;

  // a stage can load when it is empty or its item moves on
  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || core_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  // valid bits
  always_comb begin
    v_d = v_q;
    if (rdy[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // reciprocal multiply and remainder correction
  assign recip_prod = WideW'(p2_q) * WideW'(Recip);
  assign rem4       = p4_q - qm4_q;
  assign q_fix      = (CountWidth + 1)'(q0_4_q) +
                      (CountWidth + 1)'(rem4 >= ProdW'(FULL_SCALE));

  // payload stages
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      req1_q  <= req_e'(req_type_i);
      duty1_q <= duty_hundredths_i;
    end
    if (rdy[1]) begin
      req2_q  <= req1_q;
      full2_q <= duty1_q >= DUTY_W'(FULL_SCALE);
      p2_q    <= ProdW'(duty1_q[DUTY_FRAC_W-1:0]) * ProdW'(per_i);
    end
    if (rdy[2]) begin
      req3_q  <= req2_q;
      full3_q <= full2_q;
      p3_q    <= p2_q;
      q0_3_q  <= recip_prod[ProdW +: CountWidth];
    end
    if (rdy[3]) begin
      req4_q  <= req3_q;
      full4_q <= full3_q;
      p4_q    <= p3_q;
      q0_4_q  <= q0_3_q;
      qm4_q   <= ProdW'(q0_3_q) * ProdW'(FULL_SCALE);
    end
    if (rdy[4]) begin
      req5_q  <= req4_q;
      full5_q <= full4_q;
      q5_q    <= q_fix[CountWidth-1:0];
    end
  end

  assign item_o.valid = v_q[NumStages-1];
  assign item_o.req   = req5_q;
  assign item_o.full  = full5_q;
  assign quot_o       = q5_q;

  // input stalls only with every stage occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a free pipeline stage");

  // quotient estimate of a partial duty is never high and at most one low
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && req4_q == REQ_DUTY && !full4_q |->
      (p4_q >= qm4_q) && (rem4 < ProdW'(2 * FULL_SCALE)))
    else $error("reciprocal estimate out of correction range");

  // a held last stage keeps its item
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NumStages-1] && !core_ready_i |=> v_q[NumStages-1])
    else $error("pipeline item dropped under stall");

endmodule

/* rtl/core/hcpt_timer_core.sv */
module hcpt_timer_core #(
  parameter int unsigned CountWidth = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hcpt_pkg::pipe_item_t  item_i,
  input  logic [CountWidth-1:0] quot_i,
  input  logic [CountWidth-1:0] per_i,
  input  logic                  cool_mode_i,
  output logic                  core_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  heat_pin_o,
  output logic                  cool_pin_o,
  output logic [CountWidth-1:0] counter_value_o,
  output logic                  counting_o
);
  import hcpt_pkg::*;

  logic                  out_valid_q, out_valid_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  run_q, run_d;
  logic [CountWidth-1:0] heat_cmp_q, heat_cmp_d;
  logic [CountWidth-1:0] cool_cmp_q, cool_cmp_d;
  logic                  heat_lvl_q, heat_lvl_d;
  logic                  cool_lvl_q, cool_lvl_d;
  logic                  apply;

  assign core_ready_o = !out_valid_q || !out_stall_i;
  assign apply        = item_i.valid && core_ready_o;

  // result valid
  always_comb begin
    if (apply) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // timer state update for one request
  always_comb begin
    logic [CountWidth-1:0] on_cnt;
    logic [CountWidth-1:0] cnt_inc;
    logic                  hit;
    logic                  own_lvl;
    on_cnt     = item_i.full ? per_i : quot_i;
    cnt_inc    = count_q + CountWidth'(1);
    hit        = cnt_inc == per_i;
    own_lvl    = cool_mode_i ? cool_lvl_q : heat_lvl_q;
    count_d    = count_q;
    run_d      = run_q;
    heat_cmp_d = heat_cmp_q;
    cool_cmp_d = cool_cmp_q;
    heat_lvl_d = heat_lvl_q;
    cool_lvl_d = cool_lvl_q;
    if (apply) begin
      if (item_i.req == REQ_DUTY) begin
        // selected channel takes the duty, the other is parked at the period
        if (on_cnt == '0) begin
          run_d   = 1'b0;
          count_d = '0;
          own_lvl = 1'b0;
        end else if (on_cnt >= per_i) begin
          run_d   = 1'b0;
          count_d = '0;
          own_lvl = 1'b1;
        end else begin
          if (!run_q) begin
            run_d   = 1'b1;
            own_lvl = 1'b0;
          end
        end
        if (cool_mode_i) begin
          cool_lvl_d = own_lvl;
          heat_cmp_d = per_i;
          if (on_cnt != '0 && on_cnt < per_i) begin
            cool_cmp_d = per_i - on_cnt;
          end
        end else begin
          heat_lvl_d = own_lvl;
          cool_cmp_d = per_i;
          if (on_cnt != '0 && on_cnt < per_i) begin
            heat_cmp_d = per_i - on_cnt;
          end
        end
      end else if (run_q) begin
        // timer tick: period match clears, off-compare match sets the pin
        if (heat_cmp_q != per_i) begin
          if (hit) begin
            heat_lvl_d = 1'b0;
          end else if (cnt_inc == heat_cmp_q) begin
            heat_lvl_d = 1'b1;
          end
        end
        if (cool_cmp_q != per_i) begin
          if (hit) begin
            cool_lvl_d = 1'b0;
          end else if (cnt_inc == cool_cmp_q) begin
            cool_lvl_d = 1'b1;
          end
        end
        count_d = hit ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      run_q       <= 1'b0;
      heat_cmp_q  <= CountWidth'(RESET_PERIOD);
      cool_cmp_q  <= CountWidth'(RESET_PERIOD);
      heat_lvl_q  <= 1'b0;
      cool_lvl_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      run_q       <= run_d;
      heat_cmp_q  <= heat_cmp_d;
      cool_cmp_q  <= cool_cmp_d;
      heat_lvl_q  <= heat_lvl_d;
      cool_lvl_q  <= cool_lvl_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign heat_pin_o      = heat_lvl_q;
  assign cool_pin_o      = cool_lvl_q;
  assign counter_value_o = count_q;
  assign counting_o      = run_q;

  // a stopped counter always reads zero
  a_stop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> count_q == '0)
    else $error("stopped counter holds a nonzero count");

  // a duty request parks the unselected channel at the period
  a_other_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply && item_i.req == REQ_DUTY |=>
      (($past(cool_mode_i) && heat_cmp_q == $past(per_i)) ||
       (!$past(cool_mode_i) && cool_cmp_q == $past(per_i))))
    else $error("unselected channel compare not set to period");

  // a tick never leaves the count sitting on a nonzero period
  a_tick_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply && item_i.req == REQ_TICK && run_q && per_i != '0 |=>
      count_q != $past(per_i))
    else $error("period match did not clear the count");

endmodule
